FILE: hw/rtl/rdmc_pkg.sv
`timescale 1ns / 1ps

package rdmc_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam int CFG_W = 7;
	localparam int COORD_W = 6;
	localparam int REG_IDX_W = 1;

	localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b1;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] random_value;
	} in_word_t;

	typedef struct packed {
		logic               removal_valid;
		logic [COORD_W-1:0] from_row;
		logic [COORD_W-1:0] from_col;
		logic [COORD_W-1:0] to_row;
		logic [COORD_W-1:0] to_col;
		logic               finished;
	} out_word_t;

	typedef struct packed {
		logic clear;
		logic rd_en;
		logic wr_en;
	} vm_ctrl_t;

endpackage

FILE: hw/rtl/rdmc_visit_map.sv
`timescale 1ns / 1ps

// Visited bits, one memory row per grid row. A row that has not been written
// since the last clear reads as all zero.
module rdmc_visit_map #(
	parameter int ROWS = rdmc_pkg::DEF_MAX_ROWS,
	parameter int COLS = rdmc_pkg::DEF_MAX_COLS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rdmc_pkg::vm_ctrl_t       ctrl,
	input  logic [$clog2(ROWS)-1:0]  rd_a_row,
	input  logic [$clog2(ROWS)-1:0]  rd_b_row,
	input  logic [$clog2(ROWS)-1:0]  wr_row,
	input  logic [COLS-1:0]          wr_data,
	output logic [COLS-1:0]          rd_a_data,
	output logic [COLS-1:0]          rd_b_data
);

	localparam int RW = $clog2(ROWS);

	logic [COLS-1:0] map_mem_q [ROWS];
	logic [ROWS-1:0] row_valid_q;
	logic [ROWS-1:0] row_valid_d;
	logic [COLS-1:0] rd_a_q;
	logic [COLS-1:0] rd_b_q;
	logic            rd_a_valid_q;
	logic            rd_b_valid_q;

	always_comb begin
		for (int i = 0; i < ROWS; i++) begin
			row_valid_d[i] = ctrl.clear ? 1'b0 : row_valid_q[i];
			if (ctrl.wr_en && (wr_row == RW'(i))) begin
				row_valid_d[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else begin
			row_valid_q <= row_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			map_mem_q[wr_row] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_a_q       <= map_mem_q[rd_a_row];
			rd_b_q       <= map_mem_q[rd_b_row];
			rd_a_valid_q <= row_valid_q[rd_a_row];
			rd_b_valid_q <= row_valid_q[rd_b_row];
		end
	end

	assign rd_a_data = rd_a_valid_q ? rd_a_q : '0;
	assign rd_b_data = rd_b_valid_q ? rd_b_q : '0;

endmodule

FILE: hw/rtl/random_dfs_maze_carver_unit.sv
`timescale 1ns / 1ps
// A start word needs no read; its result is strobed in the following cycle.
// A step word on a non-empty stack goes through a stack read, two visited
// map row reads (the map memory has two read ports) and the update state.
// A step on an empty stack needs no read. The receiver cannot stall results.
// Reset clears the stack count and the visited row valid bits and sets both grid sizes to 64.
module random_dfs_maze_carver_unit #(
	parameter int MAX_ROWS = rdmc_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = rdmc_pkg::DEF_MAX_COLS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  rdmc_pkg::in_word_t               cmd,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rdmc_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [rdmc_pkg::CFG_W-1:0]       cfg_data,
	output logic                             result_valid,
	output rdmc_pkg::out_word_t              result
);

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int HW    = $clog2(MAX_ROWS + 1);
	localparam int WW    = $clog2(MAX_COLS + 1);
	localparam int RXW   = RW + 1;
	localparam int CXW   = CW + 1;
	localparam int EW    = RW + CW;
	localparam int SAW   = $clog2(CELLS);
	localparam int CNTW  = $clog2(CELLS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CELL = 2'd1;
	localparam logic [1:0] ST_ROW  = 2'd2;
	localparam logic [1:0] ST_EVAL = 2'd3;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	logic [1:0]                   state_q;
	logic [CNTW-1:0]              count_q;
	logic [rdmc_pkg::CFG_W-1:0]   height_q;
	logic [rdmc_pkg::CFG_W-1:0]   width_q;
	logic [7:0]                   rnd_q;
	logic [EW-1:0]                stk_mem_q [CELLS];
	logic [EW-1:0]                stk_rd_q;
	logic [MAX_COLS-1:0]          up_q;
	logic [MAX_COLS-1:0]          dn_q;
	logic                         res_v_q;
	rdmc_pkg::out_word_t          res_q;

	logic                         accept;
	logic                         acc_start;
	logic                         acc_step;
	logic [CNTW-1:0]              cnt_m1;
	logic [HW-1:0]                h_lim;
	logic [WW-1:0]                w_lim;
	logic [RW-1:0]                cur_r;
	logic [CW-1:0]                cur_c;
	logic [RXW-1:0]               r_x;
	logic [RXW-1:0]               h_x;
	logic [CXW-1:0]               c_x;
	logic [CXW-1:0]               w_x;
	logic [3:0]                   cand;
	logic [2:0]                   n_cand;
	logic [10:0]                  prod;
	logic [1:0]                   pick;
	logic [1:0]                   sel;
	logic [2:0]                   seen;
	logic                         any;
	logic [RW-1:0]                nr;
	logic [CW-1:0]                nc;
	logic [MAX_COLS-1:0]          mid_row;
	logic [MAX_COLS-1:0]          rd_a_row_data;
	logic [MAX_COLS-1:0]          rd_b_row_data;
	logic [MAX_COLS-1:0]          base_row;
	logic [CNTW-1:0]              count_next;
	rdmc_pkg::vm_ctrl_t           vm_ctrl;
	logic [RW-1:0]                vm_rd_a;
	logic [RW-1:0]                vm_rd_b;
	logic [RW-1:0]                vm_wr_row;
	logic [MAX_COLS-1:0]          vm_wr_data;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign acc_start = accept && (cmd.opcode == rdmc_pkg::OP_START);
	assign acc_step  = accept && (cmd.opcode == rdmc_pkg::OP_STEP) && (count_q != '0);
	assign cnt_m1    = count_q - CNTW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= rdmc_pkg::GRID_RESET;
			width_q  <= rdmc_pkg::GRID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rdmc_pkg::REG_HEIGHT: height_q <= cfg_data;
				rdmc_pkg::REG_WIDTH:  width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (height_q == '0) begin
			h_lim = HW'(1);
		end else if (9'(height_q) > 9'(MAX_ROWS)) begin
			h_lim = HW'(MAX_ROWS);
		end else begin
			h_lim = HW'(height_q);
		end
		if (width_q == '0) begin
			w_lim = WW'(1);
		end else if (9'(width_q) > 9'(MAX_COLS)) begin
			w_lim = WW'(MAX_COLS);
		end else begin
			w_lim = WW'(width_q);
		end
	end

	assign cur_r   = stk_rd_q[EW-1:CW];
	assign cur_c   = stk_rd_q[CW-1:0];
	assign r_x     = RXW'(cur_r);
	assign c_x     = CXW'(cur_c);
	assign h_x     = RXW'(h_lim);
	assign w_x     = CXW'(w_lim);
	assign mid_row = rd_b_row_data;

	always_comb begin
		cand[DIR_UP]    = (cur_r != '0) && ((r_x - RXW'(1)) < h_x) && (c_x < w_x)
			&& !up_q[cur_c];
		cand[DIR_DOWN]  = ((r_x + RXW'(1)) < h_x) && (c_x < w_x) && !dn_q[cur_c];
		cand[DIR_LEFT]  = (cur_c != '0) && ((c_x - CXW'(1)) < w_x) && (r_x < h_x)
			&& !mid_row[cur_c - CW'(1)];
		cand[DIR_RIGHT] = ((c_x + CXW'(1)) < w_x) && (r_x < h_x)
			&& !mid_row[cur_c + CW'(1)];
	end

	assign n_cand = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
	assign any    = (n_cand != '0);
	assign prod   = {3'b000, rnd_q} * {8'h00, n_cand};
	assign pick   = prod[9:8];

	always_comb begin
		sel  = DIR_UP;
		seen = '0;
		for (int k = 0; k < 4; k++) begin
			if (cand[k]) begin
				if (seen == {1'b0, pick}) begin
					sel = 2'(k);
				end
				seen = seen + 3'd1;
			end
		end
	end

	always_comb begin
		case (sel)
			DIR_UP: begin
				nr       = cur_r - RW'(1);
				nc       = cur_c;
				base_row = up_q;
			end
			DIR_DOWN: begin
				nr       = cur_r + RW'(1);
				nc       = cur_c;
				base_row = dn_q;
			end
			DIR_LEFT: begin
				nr       = cur_r;
				nc       = cur_c - CW'(1);
				base_row = mid_row;
			end
			DIR_RIGHT: begin
				nr       = cur_r;
				nc       = cur_c + CW'(1);
				base_row = mid_row;
			end
			default: begin
				nr       = cur_r;
				nc       = cur_c;
				base_row = mid_row;
			end
		endcase
	end

	always_comb begin
		if (any) begin
			count_next = (count_q < CNTW'(CELLS)) ? count_q + CNTW'(1) : count_q;
		end else begin
			count_next = cnt_m1;
		end
	end

	always_comb begin
		vm_ctrl    = '0;
		vm_rd_a    = cur_r - RW'(1);
		vm_rd_b    = cur_r + RW'(1);
		vm_wr_row  = nr;
		vm_wr_data = base_row | ({{(MAX_COLS-1){1'b0}}, 1'b1} << nc);
		case (state_q)
			ST_IDLE: begin
				if (acc_start) begin
					vm_ctrl.clear = 1'b1;
					vm_ctrl.wr_en = 1'b1;
					vm_wr_row     = '0;
					vm_wr_data    = {{(MAX_COLS-1){1'b0}}, 1'b1};
				end
			end
			ST_CELL: begin
				vm_ctrl.rd_en = 1'b1;
			end
			ST_ROW: begin
				vm_ctrl.rd_en = 1'b1;
				vm_rd_b       = cur_r;
			end
			ST_EVAL: begin
				vm_ctrl.wr_en = any;
			end
			default: ;
		endcase
	end

	rdmc_visit_map #(
		.ROWS (MAX_ROWS),
		.COLS (MAX_COLS)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (vm_ctrl),
		.rd_a_row  (vm_rd_a),
		.rd_b_row  (vm_rd_b),
		.wr_row    (vm_wr_row),
		.wr_data   (vm_wr_data),
		.rd_a_data (rd_a_row_data),
		.rd_b_data (rd_b_row_data)
	);

	always_ff @(posedge clk) begin
		if (acc_start) begin
			stk_mem_q[SAW'(0)] <= '0;
		end else if ((state_q == ST_EVAL) && any && (count_q < CNTW'(CELLS))) begin
			stk_mem_q[count_q[SAW-1:0]] <= {nr, nc};
		end
		if (acc_step) begin
			stk_rd_q <= stk_mem_q[cnt_m1[SAW-1:0]];
			rnd_q    <= cmd.random_value;
		end
		if (state_q == ST_ROW) begin
			up_q <= rd_a_row_data;
			dn_q <= rd_b_row_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			res_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_start) begin
						count_q <= CNTW'(1);
						res_v_q <= 1'b1;
					end else if (acc_step) begin
						state_q <= ST_CELL;
					end else if (accept) begin
						res_v_q <= 1'b1;
					end
				end
				ST_CELL: state_q <= ST_ROW;
				ST_ROW:  state_q <= ST_EVAL;
				ST_EVAL: begin
					count_q <= count_next;
					res_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !acc_step) begin
			res_q.removal_valid <= 1'b0;
			res_q.from_row      <= '0;
			res_q.from_col      <= '0;
			res_q.to_row        <= '0;
			res_q.to_col        <= '0;
			res_q.finished      <= (cmd.opcode == rdmc_pkg::OP_STEP);
		end else if (state_q == ST_EVAL) begin
			res_q.removal_valid <= any;
			res_q.from_row      <= any ? rdmc_pkg::COORD_W'(cur_r) : '0;
			res_q.from_col      <= any ? rdmc_pkg::COORD_W'(cur_c) : '0;
			res_q.to_row        <= any ? rdmc_pkg::COORD_W'(nr) : '0;
			res_q.to_col        <= any ? rdmc_pkg::COORD_W'(nc) : '0;
			res_q.finished      <= (count_next == '0);
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

`ifndef ASSERT_OFF
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (state_q == ST_IDLE))
		else $error("result strobed while a step is in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(CELLS))
		else $error("stack count beyond the stack depth");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc_start |=> (result_valid && !result.removal_valid && !result.finished))
		else $error("start word did not report a one-entry stack");

	a_removal_live: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.removal_valid) |-> !result.finished)
		else $error("wall removal reported with an empty stack");

	a_step_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc_step |-> ##4 result_valid)
		else $error("step word result not strobed four cycles after accept");
`endif

endmodule

FILE: sim/random_dfs_maze_carver_checker.sv
`timescale 1ns / 1ps

module random_dfs_maze_carver_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  rdmc_pkg::in_word_t             cmd,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [rdmc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [rdmc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           result_valid,
	input  rdmc_pkg::out_word_t            result,
	output int                             outstanding,
	output int                             mismatches
);

	localparam int CELLS = rdmc_pkg::DEF_MAX_ROWS * rdmc_pkg::DEF_MAX_COLS;

	bit                         visited_cells [CELLS];
	logic [11:0]                cell_stack [CELLS];
	int                         stack_depth;
	logic [rdmc_pkg::CFG_W-1:0] grid_rows;
	logic [rdmc_pkg::CFG_W-1:0] grid_cols;
	rdmc_pkg::out_word_t        expected_carves [$];

	function automatic int fit_dim(logic [rdmc_pkg::CFG_W-1:0] v, int top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return int'(v);
	endfunction

	function automatic void push_cell(int idx);
		if (stack_depth < CELLS) begin
			cell_stack[stack_depth] = idx[11:0];
			stack_depth++;
		end
	endfunction

	function automatic rdmc_pkg::out_word_t carve_step(rdmc_pkg::in_word_t w);
		rdmc_pkg::out_word_t r;
		int rows, cols, row, col, n, pick, k, nr, nc, nidx;
		int cand_r [4];
		int cand_c [4];
		r = '0;
		n = 0;
		if (w.opcode == rdmc_pkg::OP_START) begin
			for (k = 0; k < CELLS; k++)
				visited_cells[k] = 1'b0;
			stack_depth = 0;
			push_cell(0);
			visited_cells[0] = 1'b1;
		end else if (stack_depth > 0) begin
			rows = fit_dim(grid_rows, rdmc_pkg::DEF_MAX_ROWS);
			cols = fit_dim(grid_cols, rdmc_pkg::DEF_MAX_COLS);
			stack_depth--;
			row = int'(cell_stack[stack_depth]) / rdmc_pkg::DEF_MAX_COLS;
			col = int'(cell_stack[stack_depth]) % rdmc_pkg::DEF_MAX_COLS;
			// Neighbors are gathered in the order up, down, left, right.
			for (k = 0; k < 4; k++) begin
				nr = row + ((k == 0) ? -1 : (k == 1) ? 1 : 0);
				nc = col + ((k == 2) ? -1 : (k == 3) ? 1 : 0);
				if (nr >= 0 && nr < rows && nc >= 0 && nc < cols &&
				    !visited_cells[nr * rdmc_pkg::DEF_MAX_COLS + nc]) begin
					cand_r[n] = nr;
					cand_c[n] = nc;
					n++;
				end
			end
			if (n > 0) begin
				push_cell(row * rdmc_pkg::DEF_MAX_COLS + col);
				pick = (int'(w.random_value) * n) >> 8;
				nidx = cand_r[pick] * rdmc_pkg::DEF_MAX_COLS + cand_c[pick];
				visited_cells[nidx] = 1'b1;
				push_cell(nidx);
				r.removal_valid = 1'b1;
				r.from_row = rdmc_pkg::COORD_W'(row);
				r.from_col = rdmc_pkg::COORD_W'(col);
				r.to_row = rdmc_pkg::COORD_W'(cand_r[pick]);
				r.to_col = rdmc_pkg::COORD_W'(cand_c[pick]);
			end
		end
		r.finished = (stack_depth == 0);
		return r;
	endfunction

	task automatic check_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t carve %s: expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rdmc_pkg::out_word_t want;
		if (!arst_n) begin
			for (int k = 0; k < CELLS; k++)
				visited_cells[k] = 1'b0;
			stack_depth = 0;
			grid_rows = rdmc_pkg::GRID_RESET;
			grid_cols = rdmc_pkg::GRID_RESET;
			expected_carves.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			if (result_valid) begin
				if (expected_carves.size() == 0) begin
					$display("%0t carve: expected nothing, got %p", $time, result);
					mismatches++;
				end else begin
					want = expected_carves.pop_front();
					check_field("removal_valid", want.removal_valid, result.removal_valid);
					check_field("from_row", want.from_row, result.from_row);
					check_field("from_col", want.from_col, result.from_col);
					check_field("to_row", want.to_row, result.to_row);
					check_field("to_col", want.to_col, result.to_col);
					check_field("finished", want.finished, result.finished);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rdmc_pkg::REG_HEIGHT: begin
						grid_rows = cfg_data;
					end
					rdmc_pkg::REG_WIDTH: begin
						grid_cols = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (start && !busy)
				expected_carves = {expected_carves, carve_step(cmd)};
			outstanding = expected_carves.size();
		end
	end

endmodule

FILE: sim/tb_random_dfs_maze_carver_unit.sv
`timescale 1ns / 1ps

module tb_random_dfs_maze_carver_unit;

	localparam int CYCLE_LIMIT = 300000;
	localparam int WORD_TARGET = 950;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	rdmc_pkg::in_word_t             cmd;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [rdmc_pkg::REG_IDX_W-1:0] cfg_index;
	logic [rdmc_pkg::CFG_W-1:0]     cfg_data;
	logic                           result_valid;
	rdmc_pkg::out_word_t            result;
	int                             outstanding;
	int                             mismatches;
	int                             cycles = 0;
	int                             idle_pct;
	int                             words_sent;

	random_dfs_maze_carver_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result      (result)
	);

	random_dfs_maze_carver_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result      (result),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_word(logic op, logic [7:0] rv);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= '{opcode: op, random_value: rv};
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (outstanding != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [rdmc_pkg::REG_IDX_W-1:0] idx,
			logic [rdmc_pkg::CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_grid(logic [rdmc_pkg::CFG_W-1:0] rows, logic [rdmc_pkg::CFG_W-1:0] cols);
		drain();
		write_reg(rdmc_pkg::REG_HEIGHT, rows);
		write_reg(rdmc_pkg::REG_WIDTH, cols);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [rdmc_pkg::CFG_W-1:0] pick_dim();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return rdmc_pkg::CFG_W'($urandom_range(2, 6));
		if (r < 70)
			return 7'd1;
		if (r < 76)
			return 7'd0;
		if (r < 82)
			return 7'd64;
		if (r < 86)
			return 7'd127;
		if (r < 90)
			return rdmc_pkg::CFG_W'($urandom_range(65, 126));
		return rdmc_pkg::CFG_W'($urandom_range(7, 63));
	endfunction

	function automatic int used_dim(logic [rdmc_pkg::CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > 64)
			return 64;
		return int'(v);
	endfunction

	initial begin
		logic [rdmc_pkg::CFG_W-1:0] rows, cols;
		int phase, walks, steps;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = rdmc_pkg::REG_HEIGHT;
		cfg_data = rdmc_pkg::GRID_RESET;
		idle_pct = 0;
		words_sent = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A step with nothing on the stack, then a walk on the reset grid size.
		send_word(rdmc_pkg::OP_STEP, 8'd0);
		send_word(rdmc_pkg::OP_START, 8'd0);
		send_word(rdmc_pkg::OP_STEP, 8'd0);
		send_word(rdmc_pkg::OP_STEP, 8'd255);
		send_word(rdmc_pkg::OP_STEP, 8'd128);
		send_word(rdmc_pkg::OP_STEP, 8'd64);

		set_grid(7'd1, 7'd1);
		send_word(rdmc_pkg::OP_START, 8'd255);
		send_word(rdmc_pkg::OP_STEP, 8'd255);
		send_word(rdmc_pkg::OP_STEP, 8'd0);

		set_grid(7'd2, 7'd2);
		send_word(rdmc_pkg::OP_START, 8'd0);
		send_word(rdmc_pkg::OP_STEP, 8'd255);
		send_word(rdmc_pkg::OP_STEP, 8'd0);
		send_word(rdmc_pkg::OP_STEP, 8'd255);
		send_word(rdmc_pkg::OP_STEP, 8'd0);
		send_word(rdmc_pkg::OP_STEP, 8'd170);
		send_word(rdmc_pkg::OP_STEP, 8'd85);
		send_word(rdmc_pkg::OP_STEP, 8'd255);

		// Out of range sizes are clamped to a single row of full width.
		set_grid(7'd0, 7'd127);
		send_word(rdmc_pkg::OP_START, 8'd0);
		send_word(rdmc_pkg::OP_STEP, 8'd255);
		send_word(rdmc_pkg::OP_STEP, 8'd255);
		send_word(rdmc_pkg::OP_STEP, 8'd0);

		phase = 0;
		while (words_sent < WORD_TARGET) begin
			rows = pick_dim();
			cols = pick_dim();
			set_grid(rows, cols);
			case (phase % 4)
				0: idle_pct = 0;
				1: idle_pct = 82;
				2: idle_pct = 0;
				default: idle_pct = 9;
			endcase
			walks = $urandom_range(1, 4);
			for (int w = 0; w < walks && words_sent < WORD_TARGET; w++) begin
				// Sometimes the walk left over from the last size goes on.
				if (phase == 0 || w > 0 || $urandom_range(99) >= 15)
					send_word(rdmc_pkg::OP_START, 8'($urandom_range(255)));
				steps = 2 * used_dim(rows) * used_dim(cols) - 1;
				if (steps > 120)
					steps = $urandom_range(20, 120);
				steps += $urandom_range(0, 2);
				for (int s = 0; s < steps && words_sent < WORD_TARGET; s++) begin
					if ($urandom_range(99) < 3)
						send_word(rdmc_pkg::OP_START, 8'($urandom_range(255)));
					else
						send_word(rdmc_pkg::OP_STEP, 8'($urandom_range(255)));
				end
			end
			phase++;
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: random_dfs_maze_carver_unit.f
hw/rtl/rdmc_pkg.sv
hw/rtl/rdmc_visit_map.sv
hw/rtl/random_dfs_maze_carver_unit.sv
sim/random_dfs_maze_carver_checker.sv
sim/tb_random_dfs_maze_carver_unit.sv
